[rtl/pdmt_pkg.sv]
// ============================================================================
// pdmt_pkg: shared types and constants of the packed dna mismatch tokenizer
// Widths of the item and result fields, fold masks, controller state codes
// and the command and status bundles between controller and datapath.
// ============================================================================
package pdmt_pkg;

    // fixed field widths
    localparam int BASES   = 16;
    localparam int BASE_W  = 2;
    localparam int WORD_W  = BASES * BASE_W;
    localparam int QUAL_W  = 8;
    localparam int QHALF_W = (BASES / 2) * QUAL_W;
    localparam int LEN_W   = 11;
    localparam int RUN_W   = 11;
    localparam int GIVEN_W = 7;
    localparam int QSUM_W  = 18;
    localparam int IDX_W   = $clog2(BASES);
    localparam int DCNT_W  = $clog2(QSUM_W + 1);

    // masks that fold each two-bit base difference onto its upper bit
    localparam logic [WORD_W-1:0] ODD_MASK  = 32'hAAAA_AAAA;
    localparam logic [WORD_W-1:0] EVEN_MASK = 32'h5555_5555;

    localparam logic [QSUM_W-1:0] QSUM_MAX = '1;
    localparam logic [QUAL_W-1:0] AVG_MAX  = '1;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_DIV  = 4'b0100,
        S_END  = 4'b1000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic emit_tok;
        logic div_start;
        logic div_step;
        logic emit_end;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic flags_any;
        logic fin;
        logic div_done;
        logic out_free;
    } t_sts;

    // one result beat
    typedef struct packed {
        logic [RUN_W-1:0]  run_length;
        logic [BASE_W-1:0] ref_base;
        logic              is_end_token;
        logic [QUAL_W-1:0] avg_quality;
        logic              last;
    } t_result;

endpackage

[rtl/pdmt_if.sv]
// ============================================================================
// pdmt_if: valid/ready channels of the packed dna mismatch tokenizer
// Item channel carries one packed word pair with qualities, result channel
// carries one mismatch or end token per beat.
// ============================================================================
interface pdmt_item_if import pdmt_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [WORD_W-1:0]    query_bases;
    logic [WORD_W-1:0]    target_bases;
    logic [QHALF_W-1:0]   quals_first_half;
    logic [QHALF_W-1:0]   quals_second_half;
    logic [LEN_W-1:0]     read_length;
    logic [GIVEN_W-1:0]   given_mismatches;
    logic                 final_word;

    modport source (
        output valid, query_bases, target_bases, quals_first_half,
               quals_second_half, read_length, given_mismatches, final_word,
        input  ready
    );
    modport sink (
        input  valid, query_bases, target_bases, quals_first_half,
               quals_second_half, read_length, given_mismatches, final_word,
        output ready
    );
endinterface

interface pdmt_result_if import pdmt_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [RUN_W-1:0]     run_length;
    logic [BASE_W-1:0]    ref_base;
    logic                 is_end_token;
    logic [QUAL_W-1:0]    avg_quality;
    logic                 last;

    modport source (
        output valid, run_length, ref_base, is_end_token, avg_quality, last,
        input  ready
    );
    modport sink (
        input  valid, run_length, ref_base, is_end_token, avg_quality, last,
        output ready
    );
endinterface

[rtl/pdmt_ctrl.sv]
// ============================================================================
// pdmt_ctrl: controller of the packed dna mismatch tokenizer
// Sequences word load, mismatch scan, average division and end token.
// ============================================================================
module pdmt_ctrl import pdmt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.flags_any) begin
                    o_cmd.emit_tok = i_sts.out_free;
                end else if (i_sts.fin) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_END;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_END: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_end = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // an accepted beat always starts a scan
    a_load_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_SCAN))
        else $error("accepted beat did not start a scan");

    // results are only written into a free output register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_tok || o_cmd.emit_end) |-> i_sts.out_free)
        else $error("result emitted into a busy output register");

    // division keeps running until done
    a_div_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !i_sts.div_done) |=> (r_state == S_DIV))
        else $error("division left early");

endmodule

[rtl/pdmt_dp.sv]
// ============================================================================
// pdmt_dp: datapath of the packed dna mismatch tokenizer
// Mismatch flags, per-read run and quality state, bit-serial divider and
// the output register.
// ============================================================================
module pdmt_dp import pdmt_pkg::*; #(
    parameter int MAX_READ = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [WORD_W-1:0]  i_query_bases,
    input  logic [WORD_W-1:0]  i_target_bases,
    input  logic [QHALF_W-1:0] i_quals_first_half,
    input  logic [QHALF_W-1:0] i_quals_second_half,
    input  logic [LEN_W-1:0]   i_read_length,
    input  logic [GIVEN_W-1:0] i_given_mismatches,
    input  logic               i_final_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_result            o_out
);

    localparam int MAXW = MAX_READ / BASES;
    localparam int WCW  = $clog2(MAXW + 1);
    localparam int PW   = $clog2(MAX_READ + 1);
    localparam int CW   = (PW > LEN_W) ? PW : LEN_W;

    // per-read state
    logic [WCW-1:0]      r_wcnt, n_wcnt;
    logic [RUN_W-1:0]    r_prev, n_prev;
    logic [QSUM_W-1:0]   r_qsum, n_qsum;
    // current word
    logic [BASES-1:0]    r_flags, n_flags;
    logic [WORD_W-1:0]   r_tgt;
    logic [2*QHALF_W-1:0] r_qual;
    logic [RUN_W-1:0]    r_base;
    logic [RUN_W-1:0]    r_len;
    logic [GIVEN_W-1:0]  r_given;
    logic                r_fin;
    // divider
    logic [QSUM_W-1:0]   r_dvd, n_dvd;
    logic [GIVEN_W-1:0]  r_rem, n_rem;
    logic [DCNT_W-1:0]   r_dcnt, n_dcnt;
    // output register
    logic                r_out_valid, n_out_valid;
    t_result             r_out, n_out;

    logic [WORD_W-1:0]   w_diff, w_fold;
    logic [BASES-1:0]    w_mm, w_inlen, w_load_flags;
    logic [CW-1:0]       w_len_ext, w_len_c, w_base_ext;
    logic                w_live;
    logic [IDX_W-1:0]    w_sel;
    logic [BASES-1:0]    w_flags_rest;
    logic [RUN_W-1:0]    w_pos;
    logic [WORD_W-1:0]   w_tgt_sh;
    logic [2*QHALF_W-1:0] w_qual_sh;
    logic [QSUM_W:0]     w_qsum_add;
    logic [GIVEN_W:0]    w_trial;
    logic                w_ge;
    logic [QUAL_W-1:0]   w_avg;
    logic                w_out_free;

    // fold base differences to one flag per base, base 0 at index 0
    always_comb begin
        w_diff = i_query_bases ^ i_target_bases;
        w_fold = (w_diff & ODD_MASK) | ((w_diff & EVEN_MASK) << 1);
        for (int k = 0; k < BASES; k++) begin
            w_mm[k] = w_fold[WORD_W-1-2*k];
        end
    end

    // bases inside the read
    always_comb begin
        w_len_ext  = CW'(i_read_length);
        w_len_c    = (w_len_ext > CW'(MAX_READ)) ? CW'(MAX_READ) : w_len_ext;
        w_base_ext = CW'({r_wcnt, {IDX_W{1'b0}}});
        for (int k = 0; k < BASES; k++) begin
            w_inlen[k] = (w_base_ext + CW'(k)) < w_len_c;
        end
        w_live       = (i_given_mismatches != '0) && (r_wcnt < WCW'(MAXW));
        w_load_flags = w_live ? (w_mm & w_inlen) : '0;
    end

    // first pending mismatch
    always_comb begin
        w_sel = '0;
        for (int k = BASES - 1; k >= 0; k--) begin
            if (r_flags[k]) begin
                w_sel = IDX_W'(k);
            end
        end
        w_flags_rest        = r_flags;
        w_flags_rest[w_sel] = 1'b0;
        w_pos      = r_base + RUN_W'(w_sel);
        w_tgt_sh   = r_tgt << {w_sel, 1'b0};
        w_qual_sh  = r_qual >> {w_sel, 3'b000};
        w_qsum_add = {1'b0, r_qsum} + (QSUM_W+1)'(w_qual_sh[QUAL_W-1:0]);
    end

    // one restoring division step
    always_comb begin
        w_trial = {r_rem, r_dvd[QSUM_W-1]};
        w_ge    = w_trial >= {1'b0, r_given};
        if (r_given == '0) begin
            w_avg = '0;
        end else if (r_dvd > QSUM_W'(AVG_MAX)) begin
            w_avg = AVG_MAX;
        end else begin
            w_avg = r_dvd[QUAL_W-1:0];
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_wcnt      = r_wcnt;
        n_prev      = r_prev;
        n_qsum      = r_qsum;
        n_flags     = r_flags;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_dcnt      = r_dcnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        if (i_cmd.load) begin
            n_flags = w_load_flags;
            if (r_wcnt < WCW'(MAXW)) begin
                n_wcnt = r_wcnt + 1'b1;
            end
        end

        // mismatch token
        if (i_cmd.emit_tok) begin
            n_flags                = w_flags_rest;
            n_prev                 = w_pos;
            n_qsum                 = w_qsum_add[QSUM_W] ? QSUM_MAX
                                                        : w_qsum_add[QSUM_W-1:0];
            n_out_valid            = 1'b1;
            n_out.run_length       = w_pos - r_prev - 1'b1;
            n_out.ref_base         = w_tgt_sh[WORD_W-1 -: BASE_W];
            n_out.is_end_token     = 1'b0;
            n_out.avg_quality      = '0;
            n_out.last             = !r_fin && (w_flags_rest == '0);
        end

        // divider
        if (i_cmd.div_start) begin
            n_dvd  = r_qsum;
            n_rem  = '0;
            n_dcnt = DCNT_W'(QSUM_W);
        end
        if (i_cmd.div_step) begin
            n_rem  = w_ge ? GIVEN_W'(w_trial - {1'b0, r_given})
                          : GIVEN_W'(w_trial);
            n_dvd  = {r_dvd[QSUM_W-2:0], w_ge};
            n_dcnt = r_dcnt - 1'b1;
        end

        // end token and read restart
        if (i_cmd.emit_end) begin
            n_out_valid        = 1'b1;
            n_out.run_length   = (r_given != '0) ? (r_len - r_prev - 1'b1) : r_len;
            n_out.ref_base     = '0;
            n_out.is_end_token = 1'b1;
            n_out.avg_quality  = w_avg;
            n_out.last         = 1'b1;
            n_wcnt             = '0;
            n_prev             = '1;
            n_qsum             = '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wcnt      <= '0;
            r_prev      <= '1;
            r_qsum      <= '0;
            r_flags     <= '0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_wcnt      <= n_wcnt;
            r_prev      <= n_prev;
            r_qsum      <= n_qsum;
            r_flags     <= n_flags;
            r_dcnt      <= n_dcnt;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_out <= n_out;
        if (i_cmd.load) begin
            r_tgt   <= i_target_bases;
            r_qual  <= {i_quals_second_half, i_quals_first_half};
            r_base  <= RUN_W'(w_base_ext);
            r_len   <= RUN_W'(w_len_c);
            r_given <= i_given_mismatches;
            r_fin   <= i_final_word;
        end
    end

    assign o_sts.flags_any = (r_flags != '0);
    assign o_sts.fin       = r_fin;
    assign o_sts.div_done  = (r_dcnt == '0);
    assign o_sts.out_free  = w_out_free;
    assign o_out_valid     = r_out_valid;
    assign o_out           = r_out;

    // word count saturates at the words of the longest read
    a_wcnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wcnt <= WCW'(MAXW))
        else $error("word count past read limit");

    // end token restarts the read state
    a_end_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_end |=> (r_qsum == '0 && r_wcnt == '0 && r_prev == '1))
        else $error("read state not cleared after end token");

    // a mismatch token always lands in the output register
    a_tok_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_tok |=> (r_out_valid && !r_out.is_end_token))
        else $error("mismatch token lost");

endmodule

[rtl/packed_dna_mismatch_tokenizer.sv]
// ============================================================================
// packed_dna_mismatch_tokenizer: md-style mismatch tokens from packed bases
// Top level joining the controller and the datapath.
// ============================================================================
// Usage:
//   i_item beats carry one packed word of a read: 16 query and 16 reference
//   bases, their quality bytes, the read length, the mismatch divisor and a
//   final flag. o_res beats carry one token each: a mismatch token (matching
//   run before it and reference base) or, after the final word, the end token
//   with trailing run and average mismatch quality. last marks the final
//   token caused by an item.
//   One item is worked on at a time. The word is loaded in the idle state,
//   then the scan state emits one mismatch token per cycle while the output
//   register is free, and an empty scan returns to idle. For a final word
//   the empty scan starts a bit-serial division of the quality sum (18
//   steps and a done check); the end state then emits the end token once
//   the output register is free. The first token follows the word load.
//   A single output register holds the token; when the receiver stalls the
//   scan waits on it, and the next item is still taken while the last token
//   waits. Reset clears the read state, empties the output register and
//   starts a new read.
module packed_dna_mismatch_tokenizer import pdmt_pkg::*; #(
    parameter int MAX_READ = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pdmt_item_if.sink   i_item,
    pdmt_result_if.source o_res
);

    t_cmd    w_cmd;
    t_sts    w_sts;
    t_result w_out;
    logic    w_in_ready;
    logic    w_out_valid;

    // sequencing
    pdmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // flags, run state, divider and output register
    pdmt_dp #(
        .MAX_READ (MAX_READ)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_query_bases       (i_item.query_bases),
        .i_target_bases      (i_item.target_bases),
        .i_quals_first_half  (i_item.quals_first_half),
        .i_quals_second_half (i_item.quals_second_half),
        .i_read_length       (i_item.read_length),
        .i_given_mismatches  (i_item.given_mismatches),
        .i_final_word        (i_item.final_word),
        .o_out_valid         (w_out_valid),
        .i_out_ready         (o_res.ready),
        .o_out               (w_out)
    );

    // channel wiring
    assign i_item.ready       = w_in_ready;
    assign o_res.valid        = w_out_valid;
    assign o_res.run_length   = w_out.run_length;
    assign o_res.ref_base     = w_out.ref_base;
    assign o_res.is_end_token = w_out.is_end_token;
    assign o_res.avg_quality  = w_out.avg_quality;
    assign o_res.last         = w_out.last;

endmodule
